### src/udprx_pkg.sv
package udprx_pkg;

	// default sizing of the datagram ring
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int SLOT_BYTES_DEF  = 2048;

	// field widths
	localparam int FUNC_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int ADDR4_W  = 32;
	localparam int PORT_W   = 16;
	localparam int LEN_W    = 12;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// item function codes
	localparam logic [FUNC_W-1:0] FUNC_RECEIVE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FILTERED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TRUNCATED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_READ      = 3'd4;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEER_ADDRESS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PEER_PORT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_PORT      = 2'd3;

	// one input word as held in the input register
	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [BYTE_W-1:0]  rx_byte;
		logic               rx_first;
		logic               rx_last;
		logic [ADDR4_W-1:0] source_address;
		logic [PORT_W-1:0]  source_port;
		logic [PORT_W-1:0]  dest_port;
		logic [LEN_W-1:0]   read_limit;
	} item_t;

endpackage

### src/udprx_ram.sv
module udprx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### src/udp_rx_filter_packet_queue_unit.sv
// UDP receive filter with a ring of datagram slots.
// Input channel (item_valid / item_stall) carries one word per item: func selects
// receive byte, read byte of the oldest datagram, or clear. Received datagrams
// arrive one payload byte per word, with sender address and ports taken on the
// first byte; they are filtered, truncated to a slot and committed at the last.
// Output channel (result_valid / result_stall) returns one status word per item;
// the unused func code gives no word. Configuration (cfg_valid / cfg_ready,
// cfg_index, cfg_data) is always ready; the user is to write it only while the
// block is idle, which the block itself does not enforce. A word is registered on
// acceptance; its result is registered once the result register can advance.
// Throughput: one word per cycle unless a result is stalled; the payload store is a
// dual-port memory: a write port for received bytes, a registered read port for reads.
// Reset: queue empty, no datagram in progress, configuration zero; no clearing
// pass is needed and words are accepted right after reset.
// Stall: while result_stall holds a result, the input register keeps its word
// and item_stall rises once it is full; the held result and its read byte
// stay stable.
module udp_rx_filter_packet_queue_unit #(
	parameter int QUEUE_DEPTH = udprx_pkg::QUEUE_DEPTH_DEF,
	parameter int SLOT_BYTES  = udprx_pkg::SLOT_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [udprx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [udprx_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input words
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [udprx_pkg::FUNC_W-1:0]       func,
	input  logic [udprx_pkg::BYTE_W-1:0]       rx_byte,
	input  logic                               rx_first,
	input  logic                               rx_last,
	input  logic [udprx_pkg::ADDR4_W-1:0]      source_address,
	input  logic [udprx_pkg::PORT_W-1:0]       source_port,
	input  logic [udprx_pkg::PORT_W-1:0]       dest_port,
	input  logic [udprx_pkg::LEN_W-1:0]        read_limit,
	// result words
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic [udprx_pkg::STATUS_W-1:0]     status,
	output logic [udprx_pkg::BYTE_W-1:0]       data_byte,
	output logic                               data_last,
	output logic [udprx_pkg::ADDR4_W-1:0]      pkt_source_address,
	output logic [udprx_pkg::PORT_W-1:0]       pkt_source_port,
	output logic [udprx_pkg::PORT_W-1:0]       pkt_dest_port,
	output logic [udprx_pkg::LEN_W-1:0]        copy_length,
	output logic [udprx_pkg::COUNT_W-1:0]      queue_count,
	output logic                               pending
);

	import udprx_pkg::*;

	localparam int SLOT_W   = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
	localparam int HELD_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int OFF_W    = $clog2(SLOT_BYTES + 1);
	localparam int CMP_W    = OFF_W > LEN_W ? OFF_W : LEN_W;
	localparam int STORE_D  = QUEUE_DEPTH * SLOT_BYTES;
	localparam int STORE_AW = STORE_D > 1 ? $clog2(STORE_D) : 1;

	localparam logic [SLOT_W-1:0]   SLOT_LAST   = SLOT_W'(QUEUE_DEPTH - 1);
	localparam logic [HELD_W-1:0]   HELD_FULL   = HELD_W'(QUEUE_DEPTH);
	localparam logic [OFF_W-1:0]    OFF_LIMIT   = OFF_W'(SLOT_BYTES);
	localparam logic [STORE_AW-1:0] SLOT_STRIDE = STORE_AW'(SLOT_BYTES);

	// configuration registers
	logic               filter_enable_q;
	logic [ADDR4_W-1:0] peer_address_q;
	logic [PORT_W-1:0]  peer_port_q;
	logic [PORT_W-1:0]  own_port_q;

	// input register
	logic  item_valid_s1;
	item_t item_s1;

	// queue control state
	logic [SLOT_W-1:0] write_slot_q, read_slot_q;
	logic [HELD_W-1:0] held_count_q;
	logic [OFF_W-1:0]  write_offset_q, read_offset_q;
	logic              rx_accepting_q;
	logic [STATUS_W-1:0] drop_status_q;
	logic [LEN_W-1:0]  latched_limit_q;

	// per-slot descriptors
	logic [OFF_W-1:0]   slot_length_q [QUEUE_DEPTH];
	logic [ADDR4_W-1:0] slot_source_address_q [QUEUE_DEPTH];
	logic [PORT_W-1:0]  slot_source_port_q [QUEUE_DEPTH];
	logic [PORT_W-1:0]  slot_dest_port_q [QUEUE_DEPTH];

	// result register
	logic                result_valid_s2;
	logic [STATUS_W-1:0] status_s2;
	logic                byte_read_s2;
	logic                data_last_s2;
	logic [ADDR4_W-1:0]  pkt_source_address_s2;
	logic [PORT_W-1:0]   pkt_source_port_s2;
	logic [PORT_W-1:0]   pkt_dest_port_s2;
	logic [LEN_W-1:0]    copy_length_s2;
	logic [COUNT_W-1:0]  queue_count_s2;
	logic                pending_s2;

	// next state and result of the word in the input register
	logic                advance;
	logic [SLOT_W-1:0]   write_slot_n, read_slot_n;
	logic [HELD_W-1:0]   held_count_n;
	logic [OFF_W-1:0]    write_offset_n, read_offset_n;
	logic                rx_accepting_n;
	logic [STATUS_W-1:0] drop_status_n;
	logic [LEN_W-1:0]    latched_limit_n;
	logic                meta_we, length_we;
	logic [OFF_W-1:0]    length_val;
	logic                store_we, store_re;
	logic [STORE_AW-1:0] store_waddr, store_raddr;
	logic [BYTE_W-1:0]   store_rdata;
	logic                has_result;
	logic [STATUS_W-1:0] status_n;
	logic                byte_read_n, data_last_n;
	logic [LEN_W-1:0]    copy_length_n;

	// handshakes
	assign cfg_ready  = 1'b1;
	assign advance    = !result_valid_s2 || !result_stall;
	assign item_stall = item_valid_s1 && !advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_enable_q <= 1'b0;
			peer_address_q  <= '0;
			peer_port_q     <= '0;
			own_port_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FILTER_ENABLE: filter_enable_q <= cfg_data[0];
				REG_PEER_ADDRESS:  peer_address_q  <= cfg_data[ADDR4_W-1:0];
				REG_PEER_PORT:     peer_port_q     <= cfg_data[PORT_W-1:0];
				REG_OWN_PORT:      own_port_q      <= cfg_data[PORT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= '{func: func, rx_byte: rx_byte, rx_first: rx_first,
				rx_last: rx_last, source_address: source_address,
				source_port: source_port, dest_port: dest_port,
				read_limit: read_limit};
		end
	end

	// per-word processing
	always_comb begin
		logic              accept_now;
		logic              filter_drop;
		logic [LEN_W-1:0]  lim;
		logic [CMP_W-1:0]  len_c, lim_c, copy_c;
		logic [OFF_W-1:0]  copy_o, roff_inc;
		logic [OFF_W-1:0]  woff_inc;

		write_slot_n    = write_slot_q;
		read_slot_n     = read_slot_q;
		held_count_n    = held_count_q;
		write_offset_n  = write_offset_q;
		read_offset_n   = read_offset_q;
		rx_accepting_n  = rx_accepting_q;
		drop_status_n   = drop_status_q;
		latched_limit_n = latched_limit_q;
		meta_we     = 1'b0;
		length_we   = 1'b0;
		length_val  = write_offset_q;
		store_we    = 1'b0;
		store_re    = 1'b0;
		store_waddr = write_slot_q * SLOT_STRIDE + STORE_AW'(write_offset_q);
		store_raddr = read_slot_q * SLOT_STRIDE + STORE_AW'(read_offset_q);
		has_result    = 1'b0;
		status_n      = ST_STORED;
		byte_read_n   = 1'b0;
		data_last_n   = 1'b0;
		copy_length_n = '0;
		accept_now  = rx_accepting_q;
		filter_drop = filter_enable_q &&
			((peer_address_q != '0 && item_s1.source_address != peer_address_q) ||
			 (peer_port_q != '0 && item_s1.source_port != peer_port_q) ||
			 item_s1.dest_port != own_port_q);
		lim     = (read_offset_q == '0) ? item_s1.read_limit : latched_limit_q;
		len_c   = CMP_W'(slot_length_q[read_slot_q]);
		lim_c   = CMP_W'(lim);
		copy_c  = (len_c < lim_c) ? len_c : lim_c;
		copy_o  = OFF_W'(copy_c);
		roff_inc = read_offset_q + OFF_W'(1);
		woff_inc = write_offset_q;

		if (item_valid_s1) begin
			case (item_s1.func)
				FUNC_RECEIVE: begin
					has_result = 1'b1;
					// start of a datagram: filter, then check for room
					if (item_s1.rx_first) begin
						accept_now = 1'b0;
						woff_inc   = '0;
						if (filter_drop) begin
							drop_status_n = ST_FILTERED;
						end else if (held_count_q >= HELD_FULL) begin
							drop_status_n = ST_FULL;
						end else begin
							accept_now = 1'b1;
							meta_we    = 1'b1;
						end
					end
					store_waddr = write_slot_q * SLOT_STRIDE + STORE_AW'(woff_inc);
					if (!accept_now) begin
						status_n       = drop_status_n;
						rx_accepting_n = 1'b0;
						write_offset_n = woff_inc;
					end else begin
						rx_accepting_n = 1'b1;
						if (woff_inc < OFF_LIMIT) begin
							store_we = 1'b1;
							woff_inc = woff_inc + OFF_W'(1);
							status_n = ST_STORED;
						end else begin
							status_n = ST_TRUNCATED;
						end
						write_offset_n = woff_inc;
						// commit at the last byte
						if (item_s1.rx_last) begin
							length_we      = 1'b1;
							length_val     = woff_inc;
							write_slot_n   = (write_slot_q == SLOT_LAST) ?
								'0 : write_slot_q + SLOT_W'(1);
							held_count_n   = held_count_q + HELD_W'(1);
							write_offset_n = '0;
							rx_accepting_n = 1'b0;
						end
					end
				end
				FUNC_READ: begin
					has_result = 1'b1;
					if (held_count_q == '0) begin
						status_n = ST_EMPTY;
					end else begin
						status_n        = ST_READ;
						latched_limit_n = lim;
						copy_length_n   = LEN_W'(copy_c);
						if (read_offset_q < copy_o) begin
							store_re      = 1'b1;
							byte_read_n   = 1'b1;
							read_offset_n = roff_inc;
						end
						// final byte frees the slot
						if (read_offset_n >= copy_o) begin
							data_last_n   = 1'b1;
							read_slot_n   = (read_slot_q == SLOT_LAST) ?
								'0 : read_slot_q + SLOT_W'(1);
							held_count_n  = held_count_q - HELD_W'(1);
							read_offset_n = '0;
						end
					end
				end
				FUNC_CLEAR: begin
					has_result     = 1'b1;
					status_n       = ST_CLEARED;
					write_slot_n   = '0;
					read_slot_n    = '0;
					held_count_n   = '0;
					write_offset_n = '0;
					read_offset_n  = '0;
					rx_accepting_n = 1'b0;
					drop_status_n  = ST_FILTERED;
				end
				default: ;
			endcase
		end

		// nothing changes unless the word moves on
		if (!advance) begin
			store_we  = 1'b0;
			store_re  = 1'b0;
			meta_we   = 1'b0;
			length_we = 1'b0;
		end
	end

	// queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q    <= '0;
			read_slot_q     <= '0;
			held_count_q    <= '0;
			write_offset_q  <= '0;
			read_offset_q   <= '0;
			rx_accepting_q  <= 1'b0;
			drop_status_q   <= ST_FILTERED;
			latched_limit_q <= '0;
		end else if (advance && item_valid_s1) begin
			write_slot_q    <= write_slot_n;
			read_slot_q     <= read_slot_n;
			held_count_q    <= held_count_n;
			write_offset_q  <= write_offset_n;
			read_offset_q   <= read_offset_n;
			rx_accepting_q  <= rx_accepting_n;
			drop_status_q   <= drop_status_n;
			latched_limit_q <= latched_limit_n;
		end
	end

	// slot descriptors
	always_ff @(posedge clk) begin
		if (meta_we) begin
			slot_source_address_q[write_slot_q] <= item_s1.source_address;
			slot_source_port_q[write_slot_q]    <= item_s1.source_port;
			slot_dest_port_q[write_slot_q]      <= item_s1.dest_port;
		end
		if (length_we) begin
			slot_length_q[write_slot_q] <= length_val;
		end
	end

	// payload byte store
	udprx_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_D)
	) u_store (
		.clk     (clk),
		.wr_en   (store_we),
		.wr_addr (store_waddr),
		.wr_data (item_s1.rx_byte),
		.rd_en   (store_re),
		.rd_addr (store_raddr),
		.rd_data (store_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			result_valid_s2 <= item_valid_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_valid_s1 && has_result) begin
			status_s2      <= status_n;
			byte_read_s2   <= byte_read_n;
			data_last_s2   <= data_last_n;
			copy_length_s2 <= copy_length_n;
			queue_count_s2 <= COUNT_W'(held_count_n);
			pending_s2     <= held_count_n != '0;
			if (status_n == ST_READ) begin
				pkt_source_address_s2 <= slot_source_address_q[read_slot_q];
				pkt_source_port_s2    <= slot_source_port_q[read_slot_q];
				pkt_dest_port_s2      <= slot_dest_port_q[read_slot_q];
			end else begin
				pkt_source_address_s2 <= '0;
				pkt_source_port_s2    <= '0;
				pkt_dest_port_s2      <= '0;
			end
		end
	end

	// outputs
	assign result_valid       = result_valid_s2;
	assign status             = status_s2;
	assign data_byte          = byte_read_s2 ? store_rdata : '0;
	assign data_last          = data_last_s2;
	assign pkt_source_address = pkt_source_address_s2;
	assign pkt_source_port    = pkt_source_port_s2;
	assign pkt_dest_port      = pkt_dest_port_s2;
	assign copy_length        = copy_length_s2;
	assign queue_count        = queue_count_s2;
	assign pending            = pending_s2;

`ifndef SYNTHESIS
	// ring never holds more than its slots
	assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= HELD_FULL)
		else $error("held count above queue depth");

	// a datagram is only received into a free slot
	assert property (@(posedge clk) disable iff (!arst_n)
		rx_accepting_q |-> held_count_q < HELD_FULL)
		else $error("receiving while ring is full");

	// a partial read implies a committed datagram
	assert property (@(posedge clk) disable iff (!arst_n)
		read_offset_q != '0 |-> held_count_q != '0)
		else $error("read offset set with empty ring");

	// input only stalls behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid_s2 && result_stall)
		else $error("input stalled without a held result");

	// read byte stays put while its result is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_s2 && result_stall && byte_read_s2 |=> $stable(store_rdata))
		else $error("read byte changed under stall");
`endif

endmodule
